@@ design/indexed_min_heap_priority_queue_unit_macros.svh @@
// Assertion macros shared by the checker.
`ifndef INDEXED_MIN_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define INDEXED_MIN_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define IMHPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imhpq check failed");

// Next-cycle implication, disabled in reset.
`define IMHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imhpq check failed");

`endif

@@ design/imhpq_pkg.sv @@
`default_nettype none
package imhpq_pkg;
    localparam int DEPTH   = 64;
    localparam int KEY_W   = 8;
    localparam int PAY_W   = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int STAT_W  = 3;

    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
    localparam logic [STAT_W-1:0] ST_KEY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_TARGET = 3'd4;
    localparam logic [STAT_W-1:0] ST_RANGE  = 3'd5;

    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_PROMOTE = 2'd1;
    localparam logic [1:0] ACT_DEMOTE  = 2'd2;
    localparam logic [1:0] ACT_REMOVE  = 2'd3;

    localparam logic REG_MAX_PRIO = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_REKEY,
        OP_SORT
    } cell_op_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        cell_op_t         op;
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        logic [PAY_W-1:0] payload;
        logic             phase;
    } cell_cmd_t;
endpackage
`default_nettype wire

@@ design/indexed_min_heap_priority_queue_unit.sv @@
`default_nettype none
// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  s_tuser: action[1:0]; s_tdata: priority_req, payload
// m_*       out  m_tvalid/m_tready  m_tdata: status, top_payload, top_priority,
//                                   is_empty, entry_count
// cfg_*     in   cfg_valid/cfg_ready cfg_index 0 max_priority, 1 capacity; cfg_data
//
// An insert, a failed request and a remove pass through S_CHECK and S_DONE to the result register.
// A promote or demote adds an odd-even compare-swap pass over the chain of cells,
// one phase per cycle, until two phases in a row leave the chain untouched.
// Reset empties the queue and loads max_priority 255 and capacity 64; no clearing pass.
// A new request is taken while the previous result waits; a stalled m_tready holds
// the block in its final state until the result register frees.
module indexed_min_heap_priority_queue_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // priority_req[7:0], payload[39:8]
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // status[2:0], top_payload[34:3],
                                        // top_priority[42:35], is_empty[43],
                                        // entry_count[50:44], zero[55:51]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);
    localparam int DEPTH = imhpq_pkg::DEPTH;
    localparam int KEY_W = imhpq_pkg::KEY_W;
    localparam int PAY_W = imhpq_pkg::PAY_W;
    localparam int CNT_W = imhpq_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SORT,
        S_DONE
    } state_t;

    state_t                      state_reg;
    logic [1:0]                  act_reg;
    logic [KEY_W-1:0]            prio_reg;
    logic [PAY_W-1:0]            pay_reg;
    logic [imhpq_pkg::STAT_W-1:0] status_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        prev_swap_reg;
    logic                        phase_reg;
    logic [KEY_W-1:0]            max_reg;
    logic [CNT_W-1:0]            cap_reg;
    logic                        out_valid_reg;
    logic [55:0]                 out_data_reg;

    imhpq_pkg::entry_t    ents   [DEPTH];
    logic [DEPTH-1:0]     lts;
    logic [DEPTH-1:0]     hits_a;
    logic [DEPTH-1:0]     hits_b;
    logic [DEPTH-1:0]     swaps;
    imhpq_pkg::cell_cmd_t cmd;

    logic [CNT_W-1:0]            eff_cap;
    logic [KEY_W:0]              mid_sum;
    logic [KEY_W-1:0]            target;
    logic                        any_a;
    logic                        any_b;
    logic                        any_swap;
    logic [imhpq_pkg::STAT_W-1:0] check_status;
    imhpq_pkg::cell_op_t         check_op;
    logic                        out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign out_free  = !out_valid_reg || m_tready;

    assign eff_cap  = (cap_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_reg;
    assign mid_sum  = {1'b0, prio_reg} + {1'b0, max_reg};
    assign target   = (act_reg == imhpq_pkg::ACT_PROMOTE) ? (prio_reg >> 1)
                                                          : mid_sum[KEY_W:1];
    assign any_a    = |hits_a;
    assign any_b    = |hits_b;
    assign any_swap = |swaps;

    // decide the request's outcome from the fill count, the priority limit and the chain's match flags
    always_comb
    begin
        check_status = imhpq_pkg::ST_OK;
        check_op     = imhpq_pkg::OP_HOLD;
        count_next   = count_reg;
        case (act_reg)
            imhpq_pkg::ACT_INSERT:
            begin
                if (count_reg >= eff_cap)
                    check_status = imhpq_pkg::ST_FULL;
                else if (prio_reg > max_reg)
                    check_status = imhpq_pkg::ST_RANGE;
                else if (any_a)
                    check_status = imhpq_pkg::ST_KEY;
                else
                begin
                    check_op   = imhpq_pkg::OP_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            imhpq_pkg::ACT_PROMOTE, imhpq_pkg::ACT_DEMOTE:
            begin
                if (prio_reg > max_reg)
                    check_status = imhpq_pkg::ST_RANGE;
                else if (!any_a)
                    check_status = imhpq_pkg::ST_KEY;
                else if (any_b)
                    check_status = imhpq_pkg::ST_TARGET;
                else
                    check_op = imhpq_pkg::OP_REKEY;
            end
            default:
            begin
                if (count_reg == '0)
                    check_status = imhpq_pkg::ST_EMPTY;
                else
                begin
                    check_op   = imhpq_pkg::OP_DELETE;
                    count_next = count_reg - CNT_W'(1);
                end
            end
        endcase
    end

    always_comb
    begin
        cmd.key_a   = (act_reg == imhpq_pkg::ACT_REMOVE) ? ents[0].key : prio_reg;
        cmd.key_b   = target;
        cmd.payload = pay_reg;
        cmd.phase   = phase_reg;
        case (state_reg)
            S_CHECK: cmd.op = check_op;
            S_SORT:  cmd.op = imhpq_pkg::OP_SORT;
            default: cmd.op = imhpq_pkg::OP_HOLD;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            imhpq_pkg::entry_t left_e;
            imhpq_pkg::entry_t right_e;
            logic              left_l;
            if (gi == 0)
            begin : g_first
                assign left_e = '0;
                assign left_l = 1'b1;
            end
            else
            begin : g_mid
                assign left_e = ents[gi-1];
                assign left_l = lts[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = ents[gi+1];
            end
            imhpq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .odd       (1'(gi % 2)),
                .cmd       (cmd),
                .left_ent  (left_e),
                .right_ent (right_e),
                .left_lt   (left_l),
                .ent       (ents[gi]),
                .lt        (lts[gi]),
                .hit_a     (hits_a[gi]),
                .hit_b     (hits_b[gi]),
                .swap      (swaps[gi])
            );
        end
    endgenerate

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= 8'd255;
            cap_reg <= CNT_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == imhpq_pkg::REG_MAX_PRIO)
                max_reg <= cfg_data;
            else
                cap_reg <= cfg_data[CNT_W-1:0];
        end
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            prev_swap_reg <= 1'b1;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            act_reg       <= '0;
            prio_reg      <= '0;
            pay_reg       <= '0;
            status_reg    <= '0;
        end
        else
        begin
            // load a new result or drop the one just taken
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        act_reg   <= s_tuser;
                        prio_reg  <= s_tdata[KEY_W-1:0];
                        pay_reg   <= s_tdata[KEY_W+PAY_W-1:KEY_W];
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    status_reg    <= check_status;
                    count_reg     <= count_next;
                    prev_swap_reg <= 1'b1;
                    phase_reg     <= 1'b0;
                    state_reg     <= (check_op == imhpq_pkg::OP_REKEY) ? S_SORT : S_DONE;
                end
                S_SORT:
                begin
                    // stop after two phases in a row leave the chain untouched
                    prev_swap_reg <= any_swap;
                    phase_reg     <= !phase_reg;
                    if (!any_swap && !prev_swap_reg)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= {5'b0, count_reg, !ents[0].valid,
                                          ents[0].valid ? ents[0].key : 8'd0,
                                          ents[0].valid ? ents[0].payload : 32'd0,
                                          status_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ design/imhpq_cell.sv @@
`default_nettype none
// One slot of the sorted chain: entries stay in ascending key order, valid first.
module imhpq_cell (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    odd,
    input  wire imhpq_pkg::cell_cmd_t    cmd,
    input  wire imhpq_pkg::entry_t       left_ent,
    input  wire imhpq_pkg::entry_t       right_ent,
    input  wire logic                    left_lt,
    output imhpq_pkg::entry_t            ent,
    output logic                         lt,
    output logic                         hit_a,
    output logic                         hit_b,
    output logic                         swap
);
    imhpq_pkg::entry_t ent_reg;
    imhpq_pkg::entry_t ent_next;
    logic              sort_left;
    logic              swap_right;

    assign ent        = ent_reg;
    assign lt         = ent_reg.valid && (ent_reg.key < cmd.key_a);
    assign hit_a      = ent_reg.valid && (ent_reg.key == cmd.key_a);
    assign hit_b      = ent_reg.valid && (ent_reg.key == cmd.key_b);
    assign sort_left  = (odd == cmd.phase);
    assign swap       = (cmd.op == imhpq_pkg::OP_SORT) && sort_left && ent_reg.valid
                        && right_ent.valid && (ent_reg.key > right_ent.key);
    assign swap_right = (cmd.op == imhpq_pkg::OP_SORT) && !sort_left && ent_reg.valid
                        && left_ent.valid && (left_ent.key > ent_reg.key);

    always_comb
    begin
        ent_next = ent_reg;
        case (cmd.op)
            imhpq_pkg::OP_INSERT:
            begin
                if (!lt)
                begin
                    if (left_lt)
                    begin
                        ent_next.valid   = 1'b1;
                        ent_next.key     = cmd.key_a;
                        ent_next.payload = cmd.payload;
                    end
                    else
                    begin
                        ent_next = left_ent;
                    end
                end
            end
            imhpq_pkg::OP_DELETE:
            begin
                // close the gap: every entry at or above the removed key moves down
                if (!lt)
                begin
                    ent_next = right_ent;
                end
            end
            imhpq_pkg::OP_REKEY:
            begin
                if (hit_a)
                begin
                    ent_next.key = cmd.key_b;
                end
            end
            imhpq_pkg::OP_SORT:
            begin
                if (swap)
                begin
                    ent_next = right_ent;
                end
                else if (swap_right)
                begin
                    ent_next = left_ent;
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '0;
        end
        else
        begin
            ent_reg <= ent_next;
        end
    end
endmodule
`default_nettype wire

@@ design/imhpq_checker.sv @@
`default_nettype none
`include "indexed_min_heap_priority_queue_unit_macros.svh"
module imhpq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);
    `IMHPQ_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `IMHPQ_ASSERT_NOW(a_empty_flag, clk, rst_n, m_tvalid, m_tdata[43] == (m_tdata[50:44] == 7'd0))
    `IMHPQ_ASSERT_NOW(a_count_max, clk, rst_n, m_tvalid, m_tdata[50:44] <= 7'd64)
    `IMHPQ_ASSERT_NOW(a_empty_top, clk, rst_n, m_tvalid && m_tdata[43], m_tdata[42:3] == 40'd0)
    `IMHPQ_ASSERT_NEXT(a_busy_after_req, clk, rst_n, s_tvalid && s_tready, !s_tready)
endmodule
bind indexed_min_heap_priority_queue_unit imhpq_checker u_imhpq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
